// ----- hdl/per_source_sequence_extender_core_assert.svh -----
// Assertion macros used by the checker file of the sequence extender.
// No dependencies; each macro samples on clk and is disabled while rst_n is low.
`ifndef PER_SOURCE_SEQUENCE_EXTENDER_CORE_ASSERT_SVH
`define PER_SOURCE_SEQUENCE_EXTENDER_CORE_ASSERT_SVH

// Property that must hold in the same cycle as its trigger.
`define PSSE_ASSERT_SAME(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("%m: same-cycle check failed");

// Property that must hold in the cycle after its trigger.
`define PSSE_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("%m: next-cycle check failed");

`endif

// ----- hdl/psse_pkg.sv -----
// Package for the per-source sequence extender: item types, table entry type
// and fixed constants. No dependencies.
package psse_pkg;

    localparam int SEQ_W  = 8;
    localparam int ADDR_W = 16;
    localparam int ROLL_W = 8;
    localparam int EXT_W  = 16;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Value of the gap register after reset.
    localparam logic [SEQ_W-1:0] WRAP_GAP_RESET = 8'd250;

    typedef struct packed {
        logic [SEQ_W-1:0]  sequence_number;
        logic [ADDR_W-1:0] src_addr;
    } in_item_t;

    typedef struct packed {
        logic [EXT_W-1:0] extended_number;
        logic             rolled_over;
        logic             new_source;
        logic             table_full;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [SEQ_W-1:0]  last_number;
        logic [ROLL_W-1:0] rollovers;
    } entry_t;

endpackage

// ----- hdl/psse_front.sv -----
// Front part of the sequence extender: a short item queue that decouples the
// input side from the table engine. Depends on psse_pkg.
module psse_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  psse_pkg::in_item_t in_item,
    input  logic               deq,
    output logic               q_empty,
    output psse_pkg::in_item_t q_item
);
    import psse_pkg::*;

    in_item_t                 slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_reg, count_next;
    logic                     do_push;
    logic                     do_pop;

    // Status towards both sides.
    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign q_item  = slots_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = deq && !q_empty;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage carries no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- hdl/psse_engine.sv -----
// Back part of the sequence extender: source table memory, scan sequencer,
// rollover update and result register. Depends on psse_pkg.
module psse_engine #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  psse_pkg::in_item_t  q_item,
    output logic                deq,
    input  logic                wr_en,
    input  logic [7:0]          wr_data,
    output logic                empty,
    input  logic                pop,
    output psse_pkg::out_item_t out_item
);
    import psse_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    in_item_t          item_reg;
    logic [CNT_W-1:0]  scan_idx_reg, scan_idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    entry_t            rd_data_reg;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [SEQ_W-1:0]  gap_reg;
    logic              res_valid_reg, res_valid_next;
    out_item_t         res_reg, res_next;

    entry_t            table_mem [TABLE_DEPTH];

    logic              start;
    logic              issue;
    logic              hit;
    logic              miss_end;
    logic              room;
    logic              rolled;
    logic [ROLL_W-1:0] new_rolls;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;

    assign empty    = !res_valid_reg;
    assign out_item = res_reg;

    // Start an item once the result slot is free.
    assign start = (state_reg == ST_IDLE) && !q_empty && !res_valid_reg;
    assign deq   = start;

    // Scan: one table read issued per cycle; each read entry is then compared from its register.
    assign issue    = (state_reg == ST_SCAN) && (scan_idx_reg < used_reg);
    assign hit      = (state_reg == ST_SCAN) && rd_vld_reg
                      && (rd_data_reg.address == item_reg.src_addr);
    assign miss_end = (state_reg == ST_SCAN) && !issue && !rd_vld_reg;
    assign room     = (used_reg < DEPTH_C);

    // Rollover test for a known source.
    assign rolled = (rd_data_reg.last_number > item_reg.sequence_number)
                    && ((rd_data_reg.last_number - item_reg.sequence_number) > gap_reg);
    assign new_rolls = rd_data_reg.rollovers + ROLL_W'(rolled);

    // Table write: update on a hit, allocation on a miss with room left.
    always_comb
    begin
        mem_we    = hit || (miss_end && room);
        mem_waddr = hit ? rd_idx_reg : used_reg[IDX_W-1:0];
        mem_wdata.address     = item_reg.src_addr;
        mem_wdata.last_number = item_reg.sequence_number;
        mem_wdata.rollovers   = hit ? new_rolls : '0;
    end

    // Sequencer and result formation.
    always_comb
    begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        rd_vld_next    = 1'b0;
        used_next      = used_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_valid_reg && pop)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next    = ST_SCAN;
                    scan_idx_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next               = ST_IDLE;
                    res_valid_next           = 1'b1;
                    res_next.extended_number = {new_rolls, item_reg.sequence_number};
                    res_next.rolled_over     = rolled;
                    res_next.new_source      = 1'b0;
                    res_next.table_full      = 1'b0;
                end
                else if (miss_end)
                begin
                    state_next     = ST_IDLE;
                    res_valid_next = 1'b1;
                    if (room)
                    begin
                        used_next                = used_reg + 1'b1;
                        res_next.extended_number = {{ROLL_W{1'b0}}, item_reg.sequence_number};
                        res_next.rolled_over     = 1'b0;
                        res_next.new_source      = 1'b1;
                        res_next.table_full      = 1'b0;
                    end
                    else
                    begin
                        res_next.extended_number = '0;
                        res_next.rolled_over     = 1'b0;
                        res_next.new_source      = 1'b0;
                        res_next.table_full      = 1'b1;
                    end
                end
                else if (issue)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    rd_vld_next   = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            used_reg      <= '0;
            gap_reg       <= WRAP_GAP_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            rd_vld_reg    <= rd_vld_next;
            used_reg      <= used_next;
            res_valid_reg <= res_valid_next;
            if (wr_en)
            begin
                gap_reg <= wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg <= q_item;
        end
        if (issue)
        begin
            rd_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        res_reg <= res_next;
    end

    // Source table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (issue)
        begin
            rd_data_reg <= table_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

endmodule

// ----- hdl/per_source_sequence_extender_core.sv -----
// An item taken by an idle block is scanned against the table, one table entry being read
// per cycle and each read entry compared with the item's source, until the source is found
// or every known source has missed; the result is then registered.
// The engine starts an item only after the previous result is taken, so it does not take
// a new item while one is being scanned or its result is still waiting for the receiver.
// Reset empties the queue, the result register and the fill count and sets the gap to 250.
module per_source_sequence_extender_core #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  psse_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output psse_pkg::out_item_t out_item,
    input  logic                wr_en,
    input  logic [7:0]          wr_data
);
    import psse_pkg::*;

    logic     q_empty;
    logic     deq;
    in_item_t q_item;

    // Front part: input item queue.
    psse_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .in_item (in_item),
        .deq     (deq),
        .q_empty (q_empty),
        .q_item  (q_item)
    );

    // Back part: table scan, update and result register.
    psse_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .deq      (deq),
        .wr_en    (wr_en),
        .wr_data  (wr_data),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule

// ----- hdl/psse_checker.sv -----
// Port-level checker for the sequence extender and its bind to the top level.
// Depends on psse_pkg and per_source_sequence_extender_core_assert.svh.
`include "per_source_sequence_extender_core_assert.svh"

module psse_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input psse_pkg::out_item_t out_item
);
    import psse_pkg::*;

    logic [2:0]        outcome_flags;
    logic [ROLL_W-1:0] result_count;

    // Outcome flags and rollover count of the waiting result item.
    assign outcome_flags = {out_item.rolled_over, out_item.new_source, out_item.table_full};
    assign result_count  = out_item.extended_number[EXT_W-1:SEQ_W];

    // At most one outcome flag per result item.
    `PSSE_ASSERT_SAME(a_one_outcome, !empty, $onehot0(outcome_flags))

    // A full-table result carries a zero number.
    `PSSE_ASSERT_SAME(a_full_zero, !empty && out_item.table_full, out_item.extended_number == '0)

    // A freshly allocated source starts with a zero rollover count.
    `PSSE_ASSERT_SAME(a_new_count_zero, !empty && out_item.new_source, result_count == '0)

    // A waiting result item holds until it is taken.
    `PSSE_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(out_item))

endmodule

bind per_source_sequence_extender_core psse_checker u_psse_checker (.*);
